[hw/rtl/ierb_pkg.sv]
`default_nettype none

package ierb_pkg;

   // Input word: one send event
   typedef struct packed {
      logic [62:0] stamp_seconds;
      logic [19:0] stamp_micros;
   } req_type;

   // Output word: four packet bytes, first byte in bits 31:24
   typedef struct packed {
      logic [31:0] packet_word;
      logic        last_word;
   } rsp_type;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ADDRESS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDRESS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_IDENT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENT_SEED      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_LENGTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BYTES_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BYTES_HIGH = 3'd6;
   localparam int unsigned CSR_DATA_W = 64;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [31:0]  source_address;
      logic [31:0]  dest_address;
      logic [15:0]  echo_ident;
      logic [4:0]   fill_length;
      logic [127:0] fill_bytes;
   } cfg_type;

   // Packet layout, in 32-bit words
   localparam int unsigned HDR_BYTES   = 28;
   localparam int unsigned W_VER_LEN   = 0;
   localparam int unsigned W_IDENT     = 1;
   localparam int unsigned W_TTL_CSUM  = 2;
   localparam int unsigned W_SRC       = 3;
   localparam int unsigned W_DST       = 4;
   localparam int unsigned W_ICMP_TYPE = 5;
   localparam int unsigned W_ECHO      = 6;
   localparam int unsigned W_SEC_LO    = 7;
   localparam int unsigned W_SEC_HI    = 8;
   localparam int unsigned W_USEC_LO   = 9;
   localparam int unsigned W_USEC_HI   = 10;
   localparam int unsigned W_FILL0     = 11;

   // Header byte values
   localparam logic [7:0] VER_IHL       = 8'h45;
   localparam logic [7:0] FLAGS_DF      = 8'h40;
   localparam logic [7:0] IP_TTL        = 8'd64;
   localparam logic [7:0] PROTO_ICMP    = 8'd1;
   localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
   localparam logic [7:0] FILL_DEFAULT  = 8'h42;
   localparam int unsigned PAT_IDX_W    = 4;

   // Microprogram steps
   typedef logic [1:0] step_type;
   localparam step_type STEP_WAIT     = 2'd0;
   localparam step_type STEP_SUM_IP   = 2'd1;
   localparam step_type STEP_SUM_ICMP = 2'd2;
   localparam step_type STEP_EMIT     = 2'd3;

   // Control word of one step
   typedef struct packed {
      logic     wait_req;  // take a new input word
      logic     acc_ip;    // add generated word into the IP header sum
      logic     acc_icmp;  // add generated word into the ICMP sum
      logic     emit;      // send generated word to the output register
      logic     end_pkt;   // step ends at last packet word, else at last IP word
      logic     rewind;    // clear word and pattern counters when the step ends
      step_type next;      // jump target when the step ends
   } ctrl_type;

   // Status from the datapath back to the sequencer
   typedef struct packed {
      logic go;      // step does its work this cycle
      logic at_end;  // step reaches its end condition
   } status_type;

   // Microcode store
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type c;
      c = '0;
      case (step)
         STEP_WAIT: begin
            c.wait_req = 1'b1;
            c.rewind   = 1'b1;
            c.next     = STEP_SUM_IP;
         end
         STEP_SUM_IP: begin
            c.acc_ip = 1'b1;
            c.next   = STEP_SUM_ICMP;
         end
         STEP_SUM_ICMP: begin
            c.acc_icmp = 1'b1;
            c.end_pkt  = 1'b1;
            c.rewind   = 1'b1;
            c.next     = STEP_EMIT;
         end
         STEP_EMIT: begin
            c.emit    = 1'b1;
            c.end_pkt = 1'b1;
            c.rewind  = 1'b1;
            c.next    = STEP_WAIT;
         end
         default: c.next = STEP_WAIT;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/icmp_echo_request_builder.sv]
`default_nettype none

// Channel | Direction | Handshake               | Word
// req     | in        | req_valid / req_stall   | ierb_pkg::req_type (send timestamp)
// rsp     | out       | rsp_valid / rsp_stall   | ierb_pkg::rsp_type (packet word, last flag)
// csr     | in        | csr_write               | csr_index, csr_wdata (64 bits)
//
// A packet has W = (28+PAYLOAD_BYTES+3)/4 words (21 words at the default size). The
// block takes the input word, sums the headers and payload through the checksum adders,
// then emits the W words, one word per cycle without stall.
// Reset is synchronous and clears the step counter, counters and sequence state.
// A stall on rsp holds the emit step; the last word may wait in the output register
// while the next input word is taken.

module icmp_echo_request_builder #(
   parameter int unsigned PAYLOAD_BYTES = 56,
   parameter int unsigned PATTERN_MAX   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ierb_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ierb_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_write,
   input  wire logic [ierb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ierb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned PKT_LEN   = ierb_pkg::HDR_BYTES + PAYLOAD_BYTES;
   localparam int unsigned PKT_WORDS = (PKT_LEN + 3) / 4;

   ierb_pkg::cfg_type    cfg_ff;
   ierb_pkg::cfg_type    cfg_in;
   logic [15:0]          ident_seed_ff;
   logic [15:0]          ident_seed_in;
   logic [15:0]          echo_sequence_ff;
   logic [15:0]          echo_sequence_in;
   logic [15:0]          ip_ident_ff;
   logic [15:0]          ip_ident_in;

   ierb_pkg::ctrl_type   ctrl;
   ierb_pkg::status_type status;
   logic                 accept;
   logic                 pkt_done;

   assign req_stall = !ctrl.wait_req;
   assign accept    = req_valid && !req_stall;
   assign pkt_done  = ctrl.emit && status.go && status.at_end;

   // Register writes
   always_comb begin
      cfg_in        = cfg_ff;
      ident_seed_in = ident_seed_ff;
      if (csr_write) begin
         case (csr_index)
            ierb_pkg::CSR_SOURCE_ADDRESS:  cfg_in.source_address = csr_wdata[31:0];
            ierb_pkg::CSR_DEST_ADDRESS:    cfg_in.dest_address   = csr_wdata[31:0];
            ierb_pkg::CSR_ECHO_IDENT:      cfg_in.echo_ident     = csr_wdata[15:0];
            ierb_pkg::CSR_IDENT_SEED:      ident_seed_in         = csr_wdata[15:0];
            ierb_pkg::CSR_FILL_LENGTH:     cfg_in.fill_length    = csr_wdata[4:0];
            ierb_pkg::CSR_FILL_BYTES_LOW:  cfg_in.fill_bytes[63:0]   = csr_wdata;
            ierb_pkg::CSR_FILL_BYTES_HIGH: cfg_in.fill_bytes[127:64] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Load the IP id on accept, advance the sequence after the last word
   always_comb begin
      ip_ident_in      = ip_ident_ff;
      echo_sequence_in = echo_sequence_ff;
      if (accept) begin
         ip_ident_in = (echo_sequence_ff == 16'd0) ? ident_seed_ff : ip_ident_ff + 16'd1;
      end
      if (pkt_done) begin
         echo_sequence_in = echo_sequence_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         ident_seed_ff    <= '0;
         echo_sequence_ff <= '0;
         ip_ident_ff      <= '0;
      end else begin
         cfg_ff           <= cfg_in;
         ident_seed_ff    <= ident_seed_in;
         echo_sequence_ff <= echo_sequence_in;
         ip_ident_ff      <= ip_ident_in;
      end
   end

   ierb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   ierb_dp #(
      .PKT_LEN     (PKT_LEN),
      .PKT_WORDS   (PKT_WORDS),
      .PATTERN_MAX (PATTERN_MAX)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .cfg           (cfg_ff),
      .ip_ident      (ip_ident_ff),
      .echo_sequence (echo_sequence_ff),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   // The sequence advances by one right after the last word is loaded
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      pkt_done |=> echo_sequence_ff == $past(echo_sequence_ff) + 16'd1)
      else $error("echo sequence did not advance after packet end");

   // No new word is taken while a mid-packet word waits at the output
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(rsp_valid && !rsp_data.last_word))
      else $error("input taken in the middle of a packet");

   // A control word drives at most one kind of work
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.wait_req, ctrl.acc_ip, ctrl.acc_icmp, ctrl.emit}))
      else $error("control word selects more than one operation");

endmodule

`default_nettype wire

[hw/rtl/ierb_seq.sv]
`default_nettype none

module ierb_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ierb_pkg::status_type status,
   output ierb_pkg::ctrl_type        ctrl
);

   ierb_pkg::step_type step_ff;
   ierb_pkg::step_type step_in;

   // Fetch the control word of the current step
   assign ctrl = ierb_pkg::ucode(step_ff);

   // Stay on a step until it ends, then jump
   always_comb begin
      step_in = step_ff;
      if (status.go && status.at_end) begin
         step_in = ctrl.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ierb_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ierb_dp.sv]
`default_nettype none

module ierb_dp #(
   parameter int unsigned PKT_LEN     = 84,
   parameter int unsigned PKT_WORDS   = 21,
   parameter int unsigned PATTERN_MAX = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ierb_pkg::ctrl_type   ctrl,
   output ierb_pkg::status_type      status,
   input  wire ierb_pkg::cfg_type    cfg,
   input  wire logic [15:0]          ip_ident,
   input  wire logic [15:0]          echo_sequence,
   input  wire logic                 req_valid,
   input  wire ierb_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ierb_pkg::rsp_type         rsp_data
);

   localparam int unsigned IDX_W      = $clog2(PKT_WORDS);
   localparam int unsigned PW         = ierb_pkg::PAT_IDX_W;
   localparam int unsigned TAIL_BYTES = PKT_LEN - 4 * (PKT_WORDS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_WORDS - 1);
   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(ierb_pkg::W_DST);

   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic [PW-1:0]         pat_ff;
   logic [PW-1:0]         pat_in;
   logic [15:0]           ip_sum_ff;
   logic [15:0]           ip_sum_in;
   logic [15:0]           icmp_sum_ff;
   logic [15:0]           icmp_sum_in;
   ierb_pkg::req_type     stamp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   ierb_pkg::rsp_type     rsp_data_ff;
   ierb_pkg::rsp_type     rsp_data_in;

   logic                  out_free;
   logic                  go;
   logic                  at_end;
   logic [4:0]            plen;
   logic [PW-1:0]         pat_idx [4];
   logic [PW-1:0]         pat_adv;
   logic [31:0]           word;
   logic [63:0]           secs;
   logic [63:0]           usecs;
   logic [15:0]           ip_csum;
   logic [15:0]           icmp_csum;
   logic                  is_last;

   // Step the pattern index, wrapping at the pattern length
   function automatic logic [PW-1:0] pat_next(input logic [PW-1:0] p,
                                              input logic [4:0] len);
      logic [4:0] n;
      n = {1'b0, p} + 5'd1;
      return (n == len) ? '0 : n[PW-1:0];
   endfunction

   // Reverse byte order of a 32-bit value
   function automatic logic [31:0] bswap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Ones'-complement add of both halves of a word, end-around carry
   function automatic logic [15:0] csum_add(input logic [15:0] acc,
                                            input logic [31:0] w);
      logic [17:0] t;
      logic [16:0] f;
      logic [16:0] g;
      t = {2'b0, acc} + {2'b0, w[31:16]} + {2'b0, w[15:0]};
      f = {1'b0, t[15:0]} + {15'b0, t[17:16]};
      g = {1'b0, f[15:0]} + {16'b0, f[16]};
      return g[15:0];
   endfunction

   // Step handshake
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = ctrl.wait_req ? req_valid : (ctrl.emit ? out_free : 1'b1);
   assign at_end   = ctrl.wait_req || (idx_ff == (ctrl.end_pkt ? LAST_IDX : HDR_LAST));
   assign status.go     = go;
   assign status.at_end = at_end;

   // Clamp pattern length
   assign plen = (cfg.fill_length > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : cfg.fill_length;

   // Checksums go in only while emitting
   assign ip_csum   = ctrl.emit ? ~ip_sum_ff : 16'h0000;
   assign icmp_csum = ctrl.emit ? ~icmp_sum_ff : 16'h0000;
   assign is_last   = (idx_ff == LAST_IDX);

   assign secs  = {1'b0, stamp_ff.stamp_seconds};
   assign usecs = {44'b0, stamp_ff.stamp_micros};

   // Generate the packet word at the current index
   always_comb begin
      pat_idx[0] = pat_ff;
      for (int j = 1; j < 4; j++) begin
         pat_idx[j] = pat_next(pat_idx[j-1], plen);
      end
      pat_adv = pat_next(pat_idx[3], plen);

      case (idx_ff)
         IDX_W'(ierb_pkg::W_VER_LEN):
            word = {ierb_pkg::VER_IHL, 8'h00, 16'(PKT_LEN)};
         IDX_W'(ierb_pkg::W_IDENT):
            word = {ip_ident, ierb_pkg::FLAGS_DF, 8'h00};
         IDX_W'(ierb_pkg::W_TTL_CSUM):
            word = {ierb_pkg::IP_TTL, ierb_pkg::PROTO_ICMP, ip_csum};
         IDX_W'(ierb_pkg::W_SRC):
            word = cfg.source_address;
         IDX_W'(ierb_pkg::W_DST):
            word = cfg.dest_address;
         IDX_W'(ierb_pkg::W_ICMP_TYPE):
            word = {ierb_pkg::ICMP_ECHO_REQ, 8'h00, icmp_csum};
         IDX_W'(ierb_pkg::W_ECHO):
            word = {cfg.echo_ident, echo_sequence};
         IDX_W'(ierb_pkg::W_SEC_LO):
            word = bswap32(secs[31:0]);
         IDX_W'(ierb_pkg::W_SEC_HI):
            word = bswap32(secs[63:32]);
         IDX_W'(ierb_pkg::W_USEC_LO):
            word = bswap32(usecs[31:0]);
         IDX_W'(ierb_pkg::W_USEC_HI):
            word = bswap32(usecs[63:32]);
         default: begin
            // Fill bytes; zero the padding past the packet end
            for (int j = 0; j < 4; j++) begin
               if (is_last && (j >= int'(TAIL_BYTES))) begin
                  word[31-8*j -: 8] = 8'h00;
               end else if (plen == 5'd0) begin
                  word[31-8*j -: 8] = ierb_pkg::FILL_DEFAULT;
               end else begin
                  word[31-8*j -: 8] = cfg.fill_bytes[8*pat_idx[j] +: 8];
               end
            end
         end
      endcase
   end

   // Next values of counters, sums and the output register
   always_comb begin
      idx_in       = idx_ff;
      pat_in       = pat_ff;
      ip_sum_in    = ip_sum_ff;
      icmp_sum_in  = icmp_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (go) begin
         if (ctrl.rewind && at_end) begin
            idx_in = '0;
            pat_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff >= IDX_W'(ierb_pkg::W_FILL0)) begin
               pat_in = pat_adv;
            end
         end
         if (ctrl.wait_req) begin
            ip_sum_in   = '0;
            icmp_sum_in = '0;
         end
         if (ctrl.acc_ip) begin
            ip_sum_in = csum_add(ip_sum_ff, word);
         end
         if (ctrl.acc_icmp) begin
            icmp_sum_in = csum_add(icmp_sum_ff, word);
         end
         if (ctrl.emit) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.packet_word = word;
            rsp_data_in.last_word   = is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pat_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         pat_ff       <= pat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ip_sum_ff   <= ip_sum_in;
      icmp_sum_ff <= icmp_sum_in;
      rsp_data_ff <= rsp_data_in;
      // Hold the timestamp for the whole packet
      if (ctrl.wait_req && go) begin
         stamp_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[test/echo_packet_checker.sv]
`timescale 1ns / 1ps

// Watches the register port and both channels, builds the expected IPv4 echo
// request for every accepted send event and compares the packet words in order.
module echo_packet_checker #(
   parameter int unsigned PAYLOAD_BYTES = 56,
   parameter int unsigned PATTERN_MAX   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  ierb_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  ierb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [ierb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ierb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  words_due,
   output int                                  fail_count,
   output int                                  words_checked,
   output int                                  packets_built
);

   import ierb_pkg::*;

   localparam int unsigned IP_HDR_LEN  = 20;
   localparam int unsigned STAMP_LEN   = 16;
   localparam int unsigned FRAME_LEN   = HDR_BYTES + PAYLOAD_BYTES;
   localparam int unsigned FRAME_WORDS = (FRAME_LEN + 3) / 4;

   // register copies
   logic [31:0]  src_addr;
   logic [31:0]  dst_addr;
   logic [15:0]  echo_id;
   logic [15:0]  id_seed;
   logic [4:0]   fill_len;
   logic [127:0] fill_pattern;

   // sequence state
   logic [15:0]  seq_num;
   logic [15:0]  ip_id;

   logic [7:0]   frame [0:FRAME_WORDS*4-1];
   rsp_type      pending_words [$];
   int           mismatches;
   int           checked;
   int           packets;

   initial begin
      words_due     = 0;
      fail_count    = 0;
      words_checked = 0;
      packets_built = 0;
      mismatches    = 0;
      checked       = 0;
      packets       = 0;
   end

   function automatic void put16(input int at, input logic [15:0] v);
      frame[at]     = v[15:8];
      frame[at + 1] = v[7:0];
   endfunction

   // Internet checksum over count bytes of the frame; an odd tail byte is the high half
   function automatic logic [15:0] inet_checksum(input int first, input int count);
      logic [31:0] acc;
      int          k;
      acc = '0;
      for (k = 0; k + 1 < count; k += 2)
         acc += {16'h0, frame[first + k], frame[first + k + 1]};
      if (count % 2 != 0)
         acc += {16'h0, frame[first + count - 1], 8'h00};
      acc = (acc >> 16) + (acc & 32'h0000_FFFF);
      acc += acc >> 16;
      return ~acc[15:0];
   endfunction

   // Build the whole packet for one send event and queue its words
   task automatic predict_packet(input req_type ev);
      logic [63:0] secs;
      logic [63:0] usecs;
      int          pat_len;
      int          k;
      rsp_type     word;
      secs  = {1'b0, ev.stamp_seconds};
      usecs = {44'h0, ev.stamp_micros};
      pat_len = (fill_len > PATTERN_MAX) ? PATTERN_MAX : fill_len;
      if (seq_num == 16'h0)
         ip_id = id_seed;
      else
         ip_id = ip_id + 16'd1;
      for (k = 0; k < FRAME_WORDS * 4; k++)
         frame[k] = 8'h00;

      // IPv4 header
      frame[0] = VER_IHL;
      put16(2, 16'(FRAME_LEN));
      put16(4, ip_id);
      frame[6] = FLAGS_DF;
      frame[8] = IP_TTL;
      frame[9] = PROTO_ICMP;
      put16(12, src_addr[31:16]);
      put16(14, src_addr[15:0]);
      put16(16, dst_addr[31:16]);
      put16(18, dst_addr[15:0]);
      put16(10, inet_checksum(0, IP_HDR_LEN));

      // ICMP header
      frame[IP_HDR_LEN] = ICMP_ECHO_REQ;
      put16(IP_HDR_LEN + 4, echo_id);
      put16(IP_HDR_LEN + 6, seq_num);

      // timestamp little endian, then the fill pattern up to the packet end
      for (k = 0; k < 8; k++) begin
         frame[HDR_BYTES + k]     = secs[8*k +: 8];
         frame[HDR_BYTES + 8 + k] = usecs[8*k +: 8];
      end
      for (k = 0; k + STAMP_LEN < PAYLOAD_BYTES; k++) begin
         if (pat_len == 0)
            frame[HDR_BYTES + STAMP_LEN + k] = FILL_DEFAULT;
         else
            frame[HDR_BYTES + STAMP_LEN + k] = fill_pattern[8*(k % pat_len) +: 8];
      end
      put16(IP_HDR_LEN + 2, inet_checksum(IP_HDR_LEN, FRAME_LEN - IP_HDR_LEN));

      seq_num = seq_num + 16'd1;
      packets++;

      for (k = 0; k < FRAME_WORDS; k++) begin
         word.packet_word = {frame[4*k], frame[4*k + 1], frame[4*k + 2], frame[4*k + 3]};
         word.last_word   = (k == FRAME_WORDS - 1);
         pending_words.push_back(word);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         src_addr     = '0;
         dst_addr     = '0;
         echo_id      = '0;
         id_seed      = '0;
         fill_len     = '0;
         fill_pattern = '0;
         seq_num      = '0;
         ip_id        = '0;
         pending_words.delete();
      end else begin
         // compare an accepted word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, got %h last %b",
                        $time, rsp_data.packet_word, rsp_data.last_word);
               mismatches++;
            end else begin
               want = pending_words.pop_front();
               checked++;
               if (rsp_data.packet_word !== want.packet_word) begin
                  $display("%0t: packet_word mismatch: expected %h, got %h",
                           $time, want.packet_word, rsp_data.packet_word);
                  mismatches++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $display("%0t: last_word mismatch: expected %b, got %b",
                           $time, want.last_word, rsp_data.last_word);
                  mismatches++;
               end
            end
         end

         // track register writes
         if (csr_write) begin
            case (csr_index)
               CSR_SOURCE_ADDRESS:  src_addr = csr_wdata[31:0];
               CSR_DEST_ADDRESS:    dst_addr = csr_wdata[31:0];
               CSR_ECHO_IDENT:      echo_id = csr_wdata[15:0];
               CSR_IDENT_SEED:      id_seed = csr_wdata[15:0];
               CSR_FILL_LENGTH:     fill_len = csr_wdata[4:0];
               CSR_FILL_BYTES_LOW:  fill_pattern[63:0] = csr_wdata;
               CSR_FILL_BYTES_HIGH: fill_pattern[127:64] = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall)
            predict_packet(req_data);
      end
      words_due     <= pending_words.size();
      fail_count    <= mismatches;
      words_checked <= checked;
      packets_built <= packets;
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   import ierb_pkg::*;

   localparam int unsigned PAYLOAD_BYTES = 56;
   localparam int unsigned PATTERN_MAX   = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_EVENTS   = 43;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int words_due;
   int fail_count;
   int words_checked;
   int packets_built;

   int events_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   bit pressure_armed = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   icmp_echo_request_builder #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .PATTERN_MAX   (PATTERN_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   echo_packet_checker #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .PATTERN_MAX   (PATTERN_MAX)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .words_due     (words_due),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .packets_built (packets_built)
   );

   // one register write per cycle; caller drops csr_write when done
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // load every register, with junk in the unused upper bits
   task automatic apply_settings(input logic [31:0] src, input logic [31:0] dst,
                                 input logic [15:0] ident, input logic [15:0] seed,
                                 input logic [4:0] flen, input logic [63:0] pat_lo,
                                 input logic [63:0] pat_hi);
      write_reg(CSR_SOURCE_ADDRESS, {$urandom, src});
      write_reg(CSR_DEST_ADDRESS, {$urandom, dst});
      write_reg(CSR_ECHO_IDENT, {$urandom, 16'($urandom), ident});
      write_reg(CSR_IDENT_SEED, {$urandom, 16'($urandom), seed});
      write_reg(CSR_FILL_LENGTH, {$urandom, 27'($urandom), flen});
      write_reg(CSR_FILL_BYTES_LOW, pat_lo);
      write_reg(CSR_FILL_BYTES_HIGH, pat_hi);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // offer one send event, hold it until taken, then maybe pause
   task automatic send_event(input req_type ev);
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      events_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(20, 60)) @(posedge clock);
         else
            repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   // wait for every expected word before touching registers again
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_event(input logic [62:0] secs, input logic [19:0] usecs);
      req_type ev;
      ev.stamp_seconds = secs;
      ev.stamp_micros  = usecs;
      return ev;
   endfunction

   function automatic req_type random_event();
      req_type ev;
      case ($urandom_range(0, 7))
         0: ev.stamp_seconds = '0;
         1: ev.stamp_seconds = '1;
         default: ev.stamp_seconds = 63'({$urandom, $urandom});
      endcase
      if ($urandom_range(0, 7) == 0)
         ev.stamp_micros = 20'd999999;
      else
         ev.stamp_micros = 20'($urandom_range(0, 999999));
      return ev;
   endfunction

   // receiver: random stall modes, and once a long hold-off to fill the block
   initial begin : receiver
      int mode;
      int span;
      bit held_long;
      held_long = 1'b0;
      forever begin
         if (pressure_armed && !held_long) begin
            held_long = 1'b1;
            repeat (HOLDOFF_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         mode = $urandom_range(0, 9);
         span = $urandom_range(20, 150);
         repeat (span) begin
            case (mode)
               0, 1, 2, 3: rsp_stall <= 1'b0;
               4, 5, 6:    rsp_stall <= ($urandom_range(0, 3) == 0);
               7, 8:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [4:0] flen;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, seed at its top so the IP id wraps on the second packet
      write_reg(CSR_IDENT_SEED, 64'h0000_0000_0000_FFFF);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
      send_event(make_event('0, 20'd0));
      send_event(make_event('1, 20'd999999));
      send_event(make_event(63'h5555_5555_5555_5555, 20'h55555));
      send_event(make_event(63'h2AAA_AAAA_AAAA_AAAA, 20'hAAAAA));
      send_event(make_event('0, 20'h7FFFF));
      send_event(make_event(63'h4000_0000_0000_0000, 20'h80000));
      drain();

      // everything but the id seed at its maximum, full-length pattern of ones
      apply_settings('1, '1, '1, '0, 5'd16, '1, '1);
      send_event(make_event('1, 20'd999999));
      send_event(make_event('0, 20'd0));
      send_event(make_event('1, 20'd0));
      drain();

      // pattern length past the maximum clamps to sixteen
      apply_settings(32'hC0A8_0001, 32'h0A00_0002, 16'h1234, 16'h0,
                     5'd31, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
      send_event(make_event(63'h0123_4567_89AB_CDEF, 20'd123456));
      send_event(make_event(63'd1, 20'd1));
      drain();

      // one-byte pattern; also poke the unused register index
      apply_settings(32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 5'd1,
                     64'hFFFF_FFFF_FFFF_FFA5, 64'h0);
      write_reg(CSR_SPARE_INDEX, {$urandom, $urandom});
      csr_write <= 1'b0;
      @(posedge clock);
      send_event(make_event('1, 20'd999999));
      send_event(make_event(63'h7000_0000_0000_0001, 20'd500000));
      drain();

      // odd pattern lengths that do not divide the fill area
      apply_settings($urandom, $urandom, 16'($urandom), 16'($urandom), 5'd3,
                     {$urandom, $urandom}, {$urandom, $urandom});
      send_event(random_event());
      send_event(random_event());
      drain();
      apply_settings($urandom, $urandom, 16'($urandom), 16'($urandom), 5'd17,
                     {$urandom, $urandom}, {$urandom, $urandom});
      send_event(random_event());
      send_event(random_event());
      drain();
      apply_settings($urandom, $urandom, 16'($urandom), 16'($urandom), 5'd7,
                     {$urandom, $urandom}, {$urandom, $urandom});
      send_event(random_event());
      send_event(random_event());
      drain();

      // random part: fresh settings per phase, long hold-off early on
      pressure_armed = 1'b1;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if ($urandom_range(0, 3) == 0)
            flen = 5'd0;
         else
            flen = 5'($urandom_range(1, 31));
         apply_settings(($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom,
                        ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom,
                        16'($urandom), 16'($urandom), flen,
                        {$urandom, $urandom}, {$urandom, $urandom});
         for (int n = 0; n < PHASE_EVENTS; n++)
            send_event(random_event());
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Sent %0d send events under %0d register settings, one long receiver hold-off.",
               events_sent, settings_used);
      $display("Checked %0d packet words from %0d predicted packets.",
               words_checked, packets_built);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("Timeout with %0d words still expected.", words_due);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
